// File: hw/rtl/tgb_pkg.sv
// ============================================================================
// tgb_pkg: shared types and constants for the text gap buffer
// Command codes, store actions, the queue entry format and stream widths.
// ============================================================================
package tgb_pkg;

    // Default store capacity in characters and default command queue depth.
    localparam int CAPACITY_DEFAULT   = 4096;
    localparam int FIFO_DEPTH_DEFAULT = 4;

    // Store addresses travel at the widest width the capacity range allows.
    localparam int ADDR_MAX_W = 20;

    // Field widths of the stream payloads.
    localparam int OPCODE_W   = 3;
    localparam int CHAR_W     = 8;
    localparam int READ_IDX_W = 12;
    localparam int LEN_W      = 13;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    // Editor commands.
    typedef enum logic [OPCODE_W-1:0] {
        OP_LEFT   = 3'd0,
        OP_RIGHT  = 3'd1,
        OP_BACK   = 3'd2,
        OP_INSERT = 3'd3,
        OP_READ   = 3'd4
    } opcode_t;

    // What the back end does with the character store for one command.
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_MOVE  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } store_act_t;

    // One classified command as it sits in the queue.
    typedef struct packed {
        store_act_t              act;
        logic [ADDR_MAX_W-1:0]   rd_addr;
        logic [ADDR_MAX_W-1:0]   wr_addr;
        logic [CHAR_W-1:0]       wdata;
        logic                    read_valid;
        logic [LEN_W-1:0]        text_length;
        logic [LEN_W-1:0]        cursor_pos;
        logic                    insert_dropped;
    } tgb_cmd_t;

    // Back end sequencer states.
    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_WAIT = 1'b1
    } back_state_t;

endpackage

// File: hw/rtl/tgb_front.sv
// ============================================================================
// tgb_front: command decode and cursor bookkeeping
// Accepts commands, keeps the counts on both sides of the cursor and turns
// each command into a store action plus its finished status fields.
// ============================================================================
module tgb_front #(
    parameter int CAPACITY = tgb_pkg::CAPACITY_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] opcode, [10:3] char_in, [22:11] read_index, [23] zero
    input  logic [tgb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          q_full,
    output logic                          q_push,
    output tgb_pkg::tgb_cmd_t             q_cmd
);
    import tgb_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = (CW > READ_IDX_W) ? CW : READ_IDX_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]         before_reg;
    logic [CW-1:0]         before_next;
    logic [CW-1:0]         after_reg;
    logic [CW-1:0]         after_next;
    logic [CW-1:0]         total;
    logic [CW-1:0]         total_next;
    logic                  accept;
    opcode_t               opcode;
    logic [CHAR_W-1:0]     char_in;
    logic [READ_IDX_W-1:0] read_index;
    logic [RW-1:0]         ridx_x;
    logic [RW-1:0]         total_x;
    logic [RW-1:0]         read_addr;

    // Payload fields.
    assign opcode     = opcode_t'(s_tdata[OPCODE_W-1:0]);
    assign char_in    = s_tdata[OPCODE_W +: CHAR_W];
    assign read_index = s_tdata[OPCODE_W + CHAR_W +: READ_IDX_W];

    // A command enters whenever the queue has room.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_push   = accept;

    // Text position to store address: after the cursor, skip the gap.
    assign total   = before_reg + after_reg;
    assign ridx_x  = RW'(read_index);
    assign total_x = RW'(total);
    always_comb
    begin
        if (ridx_x < RW'(before_reg))
        begin
            read_addr = ridx_x;
        end
        else
        begin
            read_addr = ridx_x + RW'(CAP_C - total);
        end
    end

    // Classify the command and work out the new counts.
    always_comb
    begin
        before_next          = before_reg;
        after_next           = after_reg;
        q_cmd.act            = ACT_NONE;
        q_cmd.rd_addr        = '0;
        q_cmd.wr_addr        = '0;
        q_cmd.wdata          = char_in;
        q_cmd.read_valid     = 1'b0;
        q_cmd.insert_dropped = 1'b0;
        case (opcode)
            OP_LEFT:
            begin
                if (before_reg != '0)
                begin
                    q_cmd.act     = ACT_MOVE;
                    q_cmd.rd_addr = ADDR_MAX_W'(before_reg - CW'(1));
                    q_cmd.wr_addr = ADDR_MAX_W'(CAP_C - after_reg - CW'(1));
                    before_next   = before_reg - CW'(1);
                    after_next    = after_reg + CW'(1);
                end
            end
            OP_RIGHT:
            begin
                if (after_reg != '0)
                begin
                    q_cmd.act     = ACT_MOVE;
                    q_cmd.rd_addr = ADDR_MAX_W'(CAP_C - after_reg);
                    q_cmd.wr_addr = ADDR_MAX_W'(before_reg);
                    before_next   = before_reg + CW'(1);
                    after_next    = after_reg - CW'(1);
                end
            end
            OP_BACK:
            begin
                if (before_reg != '0)
                begin
                    before_next = before_reg - CW'(1);
                end
            end
            OP_INSERT:
            begin
                if (total < CAP_C)
                begin
                    q_cmd.act     = ACT_WRITE;
                    q_cmd.wr_addr = ADDR_MAX_W'(before_reg);
                    before_next   = before_reg + CW'(1);
                end
                else
                begin
                    q_cmd.insert_dropped = 1'b1;
                end
            end
            OP_READ:
            begin
                if (ridx_x < total_x)
                begin
                    q_cmd.act        = ACT_READ;
                    q_cmd.rd_addr    = ADDR_MAX_W'(read_addr);
                    q_cmd.read_valid = 1'b1;
                end
            end
            default:
            begin
                q_cmd.act = ACT_NONE;
            end
        endcase

        // Status after the command, reported at the fixed output widths.
        total_next        = before_next + after_next;
        q_cmd.text_length = LEN_W'(total_next);
        q_cmd.cursor_pos  = LEN_W'(before_next);
    end

    // Cursor counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            before_reg <= '0;
            after_reg  <= '0;
        end
        else if (accept)
        begin
            before_reg <= before_next;
            after_reg  <= after_next;
        end
    end

    // The text never outgrows the store.
    a_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, before_reg} + {1'b0, after_reg}) <= {1'b0, CAP_C})
        else $error("text longer than store capacity");

endmodule

// File: hw/rtl/tgb_queue.sv
// ============================================================================
// tgb_queue: command queue between front and back end
// A small register queue of classified commands, first in first out.
// ============================================================================
module tgb_queue #(
    parameter int DEPTH = tgb_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tgb_pkg::tgb_cmd_t push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output tgb_pkg::tgb_cmd_t head
);
    import tgb_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_C = PW'(DEPTH - 1);

    tgb_cmd_t        slots [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [NW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    // An empty or full queue has its pointers equal.
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == NW'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill level");

endmodule

// File: hw/rtl/tgb_back.sv
// ============================================================================
// tgb_back: store sequencer and result register
// Carries out queued store actions on the character store and delivers one
// result per command through an output register.
// ============================================================================
module tgb_back #(
    parameter int CAPACITY = tgb_pkg::CAPACITY_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  tgb_pkg::tgb_cmd_t             q_head,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] char_out, [8] read_valid, [21:9] text_length, [34:22] cursor_pos,
    // [35] insert_dropped, [39:36] zero
    output logic [tgb_pkg::M_TDATA_W-1:0] m_tdata
);
    import tgb_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic [CHAR_W-1:0] store_mem [CAPACITY];
    logic [CHAR_W-1:0] rd_data_reg;
    logic              mem_re;
    logic              mem_we;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic [CHAR_W-1:0] wdata;

    back_state_t       state_reg;
    back_state_t       state_next;
    tgb_cmd_t          cur_reg;
    logic              cur_load;
    logic              take;
    logic              out_free;

    logic              out_valid_reg;
    tgb_cmd_t          out_cmd_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_load;
    tgb_cmd_t          out_cmd;
    logic [CHAR_W-1:0] out_char;

    // A new command starts only when its result has somewhere to go.
    assign out_free = !out_valid_reg || m_tready;
    assign take     = (state_reg == BK_IDLE) && !q_empty && out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (take && (q_head.act == ACT_MOVE || q_head.act == ACT_READ))
                begin
                    state_next = BK_WAIT;
                end
            end
            BK_WAIT:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Store accesses, queue pop and result load.
    always_comb
    begin
        q_pop    = 1'b0;
        cur_load = 1'b0;
        mem_re   = 1'b0;
        mem_we   = 1'b0;
        raddr    = q_head.rd_addr[AW-1:0];
        waddr    = q_head.wr_addr[AW-1:0];
        wdata    = q_head.wdata;
        out_load = 1'b0;
        out_cmd  = q_head;
        out_char = '0;
        case (state_reg)
            BK_IDLE:
            begin
                if (take)
                begin
                    q_pop = 1'b1;
                    case (q_head.act)
                        ACT_MOVE, ACT_READ:
                        begin
                            mem_re   = 1'b1;
                            cur_load = 1'b1;
                        end
                        ACT_WRITE:
                        begin
                            mem_we   = 1'b1;
                            out_load = 1'b1;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            BK_WAIT:
            begin
                out_load = 1'b1;
                out_cmd  = cur_reg;
                waddr    = cur_reg.wr_addr[AW-1:0];
                wdata    = rd_data_reg;
                case (cur_reg.act)
                    ACT_MOVE:
                    begin
                        mem_we = 1'b1;
                    end
                    ACT_READ:
                    begin
                        out_char = rd_data_reg;
                    end
                    default:
                    begin
                        out_char = '0;
                    end
                endcase
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Character store with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[raddr];
        end
    end

    // Command held while its store read completes.
    always_ff @(posedge clk)
    begin
        if (cur_load)
        begin
            cur_reg <= q_head;
        end
    end

    // Sequencer state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cmd_reg  <= out_cmd;
            out_char_reg <= out_char;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_cmd_reg.insert_dropped, out_cmd_reg.cursor_pos,
                       out_cmd_reg.text_length, out_cmd_reg.read_valid, out_char_reg};

    // While a read is outstanding the queue holds still.
    a_no_pop_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_WAIT) |-> !q_pop)
        else $error("queue popped during store read");

    // A waiting result is never overwritten.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !out_load)
        else $error("result register overrun");

    // The result slot is free whenever a store read finishes.
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_WAIT) |-> !out_valid_reg)
        else $error("result slot busy when store read finished");

endmodule

// File: hw/rtl/text_gap_buffer.sv
// ============================================================================
// text_gap_buffer: line editor held as a gap buffer
// Commands move the cursor, delete, insert and read characters of a text
// kept in a fixed-size character store; each command returns one status.
//
//   Channel   Direction  Payload (low bits first)
//   s_*       in         opcode, char_in, read_index
//   m_*       out        char_out, read_valid, text_length, cursor_pos,
//                        insert_dropped
//
// The front end accepts one command per cycle while the command queue has
// room. In the back end, inserts and storeless commands finish in the idle
// state; cursor moves and reads pass the wait state, since the store read
// must return before the moved character is written or the result is
// formed. Reset clears the cursor counts, queue and sequencer; the store is
// not cleared. Output stalls back up into the queue and then into s_tready.
// ============================================================================
module text_gap_buffer #(
    parameter int CAPACITY   = tgb_pkg::CAPACITY_DEFAULT,
    parameter int FIFO_DEPTH = tgb_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] opcode, [10:3] char_in, [22:11] read_index, [23] zero
    input  logic [tgb_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] char_out, [8] read_valid, [21:9] text_length, [34:22] cursor_pos,
    // [35] insert_dropped, [39:36] zero
    output logic [tgb_pkg::M_TDATA_W-1:0] m_tdata
);
    import tgb_pkg::*;

    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    tgb_cmd_t push_cmd;
    tgb_cmd_t head_cmd;

    // Decode and cursor bookkeeping.
    tgb_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // Command queue.
    tgb_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head_cmd)
    );

    // Store sequencer and result register.
    tgb_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
